[src/cdmsf_pkg.sv]
// Shared types, constants and BCD helpers for the CD minute/second/frame position unit.
// No dependencies; every other source file imports this package.
package cdmsf_pkg;

    localparam int unsigned ADDR_W         = 19;
    localparam int unsigned FRAMES_PER_SEC = 75;
    localparam int unsigned SECS_PER_MIN   = 60;
    localparam int unsigned FRAMES_PER_MIN = SECS_PER_MIN * FRAMES_PER_SEC;
    localparam int unsigned SEEK_LIMIT     = 449999;

    localparam int unsigned QUOT_W      = 7;
    localparam int unsigned REM_W       = 13;
    localparam int unsigned MIN_RECIP_W = 20;
    localparam int unsigned MIN_PROD_W  = ADDR_W + MIN_RECIP_W;
    localparam int unsigned MIN_SHIFT   = 32;
    localparam int unsigned SEC_RECIP_W = 10;
    localparam int unsigned SEC_PROD_W  = REM_W + SEC_RECIP_W;
    localparam int unsigned SEC_SHIFT   = 16;

    localparam logic [MIN_RECIP_W-1:0] MIN_RECIP = MIN_RECIP_W'(954438);
    localparam logic [SEC_RECIP_W-1:0] SEC_RECIP = SEC_RECIP_W'(874);

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_STEP  = 2'd1;
    localparam logic [1:0] ACT_SEEK  = 2'd2;
    localparam logic [1:0] ACT_QUERY = 2'd3;

    localparam logic [7:0] FRAME_WRAP      = 8'h75;
    localparam logic [7:0] SECOND_WRAP     = 8'h60;
    localparam logic [7:0] MINUTE_LAST     = 8'h99;
    localparam logic [7:0] REL_SECOND_FLAG = 8'h80;
    localparam logic [3:0] BCD_NINE        = 4'h9;

    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 72;

    typedef struct packed {
        logic [7:0] minute;
        logic [7:0] second;
        logic [7:0] frame;
    } msf_t;

    typedef struct packed {
        logic [1:0] action;
        msf_t       load;
        msf_t       track;
    } cmd_t;

    typedef struct packed {
        logic [7:0]        track_frame;
        logic [7:0]        track_second;
        logic [7:0]        track_minute;
        logic [ADDR_W-1:0] seek_address;
        logic [7:0]        load_frame;
        logic [7:0]        load_second;
        logic [7:0]        load_minute;
    } s_payload_t;

    typedef struct packed {
        logic [7:0]        report_frame;
        logic [7:0]        report_second;
        logic [7:0]        report_minute;
        logic [ADDR_W-1:0] linear_address;
        logic [7:0]        pos_frame;
        logic [7:0]        pos_second;
        logic [7:0]        pos_minute;
    } result_t;

    localparam int unsigned S_PAYLOAD_W = $bits(s_payload_t);
    localparam int unsigned RESULT_W    = $bits(result_t);

    function automatic logic [7:0] bcd_step(input logic [7:0] v);
        logic [7:0] r;
        if (v[3:0] == BCD_NINE) begin
            r = {v[7:4] + 4'h1, 4'h0};
        end else begin
            r = v + 8'd1;
        end
        return r;
    endfunction

    function automatic logic [7:0] bcd_value(input logic [7:0] v);
        return {1'b0, v[7:4], 3'b000} + {3'b000, v[7:4], 1'b0} + {4'h0, v[3:0]};
    endfunction

    function automatic logic [7:0] to_bcd(input logic [QUOT_W-1:0] v);
        logic [3:0]        tens;
        logic [QUOT_W-1:0] ones;
        tens = 4'h0;
        for (int i = 1; i <= 9; i++) begin
            if (v >= QUOT_W'(10 * i)) begin
                tens = 4'(i);
            end
        end
        ones = v - QUOT_W'(32'(tens) * 10);
        return {tens, ones[3:0]};
    endfunction

endpackage

[src/cdmsf_seek_conv.sv]
// Seek address conversion: clamp, divide by frames per minute and per second, convert to BCD.
// Four registered stages with per-stage handshake. Depends on cdmsf_pkg.
module cdmsf_seek_conv
    import cdmsf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  cmd_t              in_cmd,
    input  logic [ADDR_W-1:0] in_addr,
    output logic              out_valid,
    input  logic              out_ready,
    output cmd_t              out_cmd,
    output msf_t              out_seek
);

    logic              a_valid_reg;
    cmd_t              a_cmd_reg;
    logic [ADDR_W-1:0] a_addr_reg;
    logic [QUOT_W-1:0] a_min_reg;

    logic              b_valid_reg;
    cmd_t              b_cmd_reg;
    logic [QUOT_W-1:0] b_min_reg;
    logic [REM_W-1:0]  b_rem_reg;

    logic              c_valid_reg;
    cmd_t              c_cmd_reg;
    logic [QUOT_W-1:0] c_min_reg;
    logic [REM_W-1:0]  c_rem_reg;
    logic [QUOT_W-1:0] c_sec_reg;

    logic              d_valid_reg;
    cmd_t              d_cmd_reg;
    msf_t              d_seek_reg;

    logic a_ready, b_ready, c_ready, d_ready;

    logic [ADDR_W-1:0]     clamp_addr;
    logic [MIN_PROD_W-1:0] min_prod;
    logic [ADDR_W-1:0]     rem_full;
    logic [SEC_PROD_W-1:0] sec_prod;
    logic [REM_W-1:0]      frame_full;
    msf_t                  seek_next;

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign clamp_addr = (in_addr > ADDR_W'(SEEK_LIMIT)) ? ADDR_W'(SEEK_LIMIT) : in_addr;
    assign min_prod   = MIN_PROD_W'(clamp_addr) * MIN_PROD_W'(MIN_RECIP);
    assign rem_full   = a_addr_reg - ADDR_W'(a_min_reg) * ADDR_W'(FRAMES_PER_MIN);
    assign sec_prod   = SEC_PROD_W'(b_rem_reg) * SEC_PROD_W'(SEC_RECIP);
    assign frame_full = c_rem_reg - REM_W'(c_sec_reg) * REM_W'(FRAMES_PER_SEC);

    always_comb begin
        seek_next.minute = to_bcd(c_min_reg);
        seek_next.second = to_bcd(c_sec_reg);
        seek_next.frame  = to_bcd(frame_full[QUOT_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_ready) begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_cmd_reg  <= in_cmd;
            a_addr_reg <= clamp_addr;
            a_min_reg  <= min_prod[MIN_SHIFT +: QUOT_W];
        end
        if (b_ready && a_valid_reg) begin
            b_cmd_reg <= a_cmd_reg;
            b_min_reg <= a_min_reg;
            b_rem_reg <= rem_full[REM_W-1:0];
        end
        if (c_ready && b_valid_reg) begin
            c_cmd_reg <= b_cmd_reg;
            c_min_reg <= b_min_reg;
            c_rem_reg <= b_rem_reg;
            c_sec_reg <= sec_prod[SEC_SHIFT +: QUOT_W];
        end
        if (d_ready && c_valid_reg) begin
            d_cmd_reg  <= c_cmd_reg;
            d_seek_reg <= seek_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_cmd   = d_cmd_reg;
    assign out_seek  = d_seek_reg;

endmodule

[src/cdmsf_pos_core.sv]
// Position register: applies load, frame step with BCD carry, seek or query to the held position.
// Depends on cdmsf_pkg.
module cdmsf_pos_core
    import cdmsf_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    input  msf_t in_seek,
    output logic out_valid,
    input  logic out_ready,
    output msf_t out_pos,
    output msf_t out_track
);

    logic valid_reg;
    msf_t pos_reg;
    msf_t pos_next;
    msf_t track_reg;
    msf_t stepped;
    logic [7:0] step_frame;
    logic [7:0] step_second;
    logic [7:0] step_minute;

    assign in_ready = !valid_reg || out_ready;

    assign step_frame  = bcd_step(pos_reg.frame);
    assign step_second = bcd_step(pos_reg.second);
    assign step_minute = (pos_reg.minute == MINUTE_LAST) ? 8'h00 : bcd_step(pos_reg.minute);

    always_comb begin
        stepped = pos_reg;
        if (step_frame == FRAME_WRAP) begin
            stepped.frame = 8'h00;
            if (step_second == SECOND_WRAP) begin
                stepped.second = 8'h00;
                stepped.minute = step_minute;
            end else begin
                stepped.second = step_second;
            end
        end else begin
            stepped.frame = step_frame;
        end
    end

    always_comb begin
        unique case (in_cmd.action)
            ACT_LOAD:  pos_next = in_cmd.load;
            ACT_STEP:  pos_next = stepped;
            ACT_SEEK:  pos_next = in_seek;
            ACT_QUERY: pos_next = pos_reg;
            default:   pos_next = pos_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (in_ready && in_valid) begin
                pos_reg <= pos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            track_reg <= in_cmd.track;
        end
    end

    assign out_valid = valid_reg;
    assign out_pos   = pos_reg;
    assign out_track = track_reg;

endmodule

[src/cdmsf_report.sv]
// Result register: linear address from the BCD position and the absolute or relative report.
// Depends on cdmsf_pkg.
module cdmsf_report
    import cdmsf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  msf_t    in_pos,
    input  msf_t    in_track,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result,
    output logic    out_relative
);

    logic              valid_reg;
    result_t           result_reg;
    logic              relative_reg;
    result_t           result_next;
    logic              relative_next;
    logic [ADDR_W-1:0] lin_next;

    assign in_ready = !valid_reg || out_ready;

    assign lin_next = ADDR_W'(bcd_value(in_pos.minute)) * ADDR_W'(FRAMES_PER_MIN)
                    + ADDR_W'(bcd_value(in_pos.second)) * ADDR_W'(FRAMES_PER_SEC)
                    + ADDR_W'(bcd_value(in_pos.frame));

    assign relative_next = |in_pos.frame[4:0];

    always_comb begin
        result_next.pos_minute     = in_pos.minute;
        result_next.pos_second     = in_pos.second;
        result_next.pos_frame      = in_pos.frame;
        result_next.linear_address = lin_next;
        if (relative_next) begin
            result_next.report_minute = in_pos.minute - in_track.minute;
            result_next.report_second = (in_pos.second - in_track.second) | REL_SECOND_FLAG;
            result_next.report_frame  = in_pos.frame - in_track.frame;
        end else begin
            result_next.report_minute = in_pos.minute;
            result_next.report_second = in_pos.second;
            result_next.report_frame  = in_pos.frame;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            result_reg   <= result_next;
            relative_reg <= relative_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_result   = result_reg;
    assign out_relative = relative_reg;

endmodule

[src/cd_msf_position_unit.sv]
// CD minute/second/frame position unit, top level: input register, seek conversion,
// position register and result register. Depends on cdmsf_pkg and the cdmsf_* modules.
// Throughput: one transaction per cycle while m_tready is high; each stage holds one item and is freed as it drains.
// Reset (aresetn low, synchronous): empties every stage and sets the position to 00:00:00.
module cd_msf_position_unit
    import cdmsf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // load_minute, load_second, load_frame, seek_address, track_minute, track_second,
    // track_frame, zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pos_minute, pos_second, pos_frame, linear_address, report_minute, report_second,
    // report_frame, zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    // report_relative
    output logic                 m_tuser
);

    logic              in_valid_reg;
    cmd_t              in_cmd_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    s_payload_t        s_payload;
    cmd_t              in_cmd_next;

    logic seek_in_ready;
    logic seek_valid;
    logic pos_in_ready;
    cmd_t seek_cmd;
    msf_t seek_msf;

    logic pos_valid;
    logic rep_in_ready;
    msf_t pos_msf;
    msf_t track_msf;

    result_t result;

    assign s_payload = s_payload_t'(s_tdata[S_PAYLOAD_W-1:0]);

    always_comb begin
        in_cmd_next.action       = s_tuser;
        in_cmd_next.load.minute  = s_payload.load_minute;
        in_cmd_next.load.second  = s_payload.load_second;
        in_cmd_next.load.frame   = s_payload.load_frame;
        in_cmd_next.track.minute = s_payload.track_minute;
        in_cmd_next.track.second = s_payload.track_second;
        in_cmd_next.track.frame  = s_payload.track_frame;
    end

    assign s_tready = !in_valid_reg || seek_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg  <= in_cmd_next;
            in_addr_reg <= s_payload.seek_address;
        end
    end

    cdmsf_seek_conv u_seek_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_ready  (seek_in_ready),
        .in_cmd    (in_cmd_reg),
        .in_addr   (in_addr_reg),
        .out_valid (seek_valid),
        .out_ready (pos_in_ready),
        .out_cmd   (seek_cmd),
        .out_seek  (seek_msf)
    );

    cdmsf_pos_core u_pos_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (seek_valid),
        .in_ready  (pos_in_ready),
        .in_cmd    (seek_cmd),
        .in_seek   (seek_msf),
        .out_valid (pos_valid),
        .out_ready (rep_in_ready),
        .out_pos   (pos_msf),
        .out_track (track_msf)
    );

    cdmsf_report u_report (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (pos_valid),
        .in_ready     (rep_in_ready),
        .in_pos       (pos_msf),
        .in_track     (track_msf),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_result   (result),
        .out_relative (m_tuser)
    );

    assign m_tdata = {(M_TDATA_W - RESULT_W)'(0), result};

endmodule

[src/cdmsf_checker.sv]
// Port-level checks for cd_msf_position_unit, attached by the bind at the end of this file.
// Depends on cdmsf_pkg.
module cdmsf_checker
    import cdmsf_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    result_t res;

    assign res = result_t'(m_tdata[RESULT_W-1:0]);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result channel valid after reset");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result transaction changed");

    a_relative_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == (res.pos_frame[4:0] != 5'd0)))
        else $error("report kind does not match frame byte");

    a_absolute_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> res.report_minute == res.pos_minute
                              && res.report_second == res.pos_second
                              && res.report_frame == res.pos_frame)
        else $error("absolute report differs from position");

    a_relative_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> res.report_second[7])
        else $error("relative report second lacks its mark bit");

endmodule

bind cd_msf_position_unit cdmsf_checker u_checker (.*);

[verif/cd_msf_position_unit_checker.sv]
`timescale 1ns / 1ps
// Result checker for cd_msf_position_unit: tracks the disc position from accepted commands,
// predicts each position report and compares it with the result transactions in order.
// Depends on cdmsf_pkg for the payload layouts, action codes and BCD constants.
module cd_msf_position_unit_checker
    import cdmsf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tuser,
    output int                   fail_count,
    output int                   outstanding
);

    typedef struct packed {
        result_t fields;
        logic    relative;
    } pos_report_t;

    msf_t        position;
    pos_report_t pending_reports[$];
    pos_report_t got_report;
    pos_report_t want_report;

    function automatic logic [7:0] digit_advance(input logic [7:0] v);
        if (v[3:0] == 4'h9) begin
            return {v[7:4] + 4'h1, 4'h0};
        end
        return v + 8'd1;
    endfunction

    function automatic int unsigned bcd_decode(input logic [7:0] v);
        return int'(v[7:4]) * 10 + int'(v[3:0]);
    endfunction

    function automatic logic [7:0] bcd_encode(input int unsigned v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    function automatic pos_report_t apply_command(input logic [1:0] act, input s_payload_t cmd);
        int unsigned addr;
        int unsigned lba;
        pos_report_t r;
        case (act)
            ACT_LOAD: begin
                position.minute = cmd.load_minute;
                position.second = cmd.load_second;
                position.frame  = cmd.load_frame;
            end
            ACT_STEP: begin
                position.frame = digit_advance(position.frame);
                if (position.frame == FRAME_WRAP) begin
                    position.frame  = 8'h00;
                    position.second = digit_advance(position.second);
                    if (position.second == SECOND_WRAP) begin
                        position.second = 8'h00;
                        position.minute = (position.minute == MINUTE_LAST) ?
                                          8'h00 : digit_advance(position.minute);
                    end
                end
            end
            ACT_SEEK: begin
                addr = cmd.seek_address;
                if (addr > SEEK_LIMIT) begin
                    addr = SEEK_LIMIT;
                end
                position.minute = bcd_encode(addr / FRAMES_PER_MIN);
                addr            = addr % FRAMES_PER_MIN;
                position.second = bcd_encode(addr / FRAMES_PER_SEC);
                position.frame  = bcd_encode(addr % FRAMES_PER_SEC);
            end
            default: begin
            end
        endcase
        lba = bcd_decode(position.minute) * FRAMES_PER_MIN
            + bcd_decode(position.second) * FRAMES_PER_SEC
            + bcd_decode(position.frame);
        r.fields.pos_minute     = position.minute;
        r.fields.pos_second     = position.second;
        r.fields.pos_frame      = position.frame;
        r.fields.linear_address = ADDR_W'(lba);
        if (position.frame[4:0] == 5'd0) begin
            r.fields.report_minute = position.minute;
            r.fields.report_second = position.second;
            r.fields.report_frame  = position.frame;
            r.relative             = 1'b0;
        end else begin
            r.fields.report_minute = position.minute - cmd.track_minute;
            r.fields.report_second = (position.second - cmd.track_second) | REL_SECOND_FLAG;
            r.fields.report_frame  = position.frame - cmd.track_frame;
            r.relative             = 1'b1;
        end
        return r;
    endfunction

    function automatic string describe(input pos_report_t r);
        return $sformatf("pos %h:%h:%h lba %0d report %h:%h:%h rel %b",
                         r.fields.pos_minute, r.fields.pos_second, r.fields.pos_frame,
                         r.fields.linear_address, r.fields.report_minute,
                         r.fields.report_second, r.fields.report_frame, r.relative);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            position = '0;
            pending_reports.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                pending_reports.push_back(
                    apply_command(s_tuser, s_payload_t'(s_tdata[S_PAYLOAD_W-1:0])));
            end
            if (m_tvalid && m_tready) begin
                got_report.fields   = result_t'(m_tdata[RESULT_W-1:0]);
                got_report.relative = m_tuser;
                if (pending_reports.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result transaction: %s", describe(got_report));
                    end
                end else begin
                    want_report = pending_reports.pop_front();
                    if (got_report !== want_report) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: expected %s", describe(want_report));
                            $display("          actual   %s", describe(got_report));
                        end
                    end
                end
            end
        end
        outstanding = pending_reports.size();
    end

endmodule

[verif/cd_msf_position_unit_tb.sv]
`timescale 1ns / 1ps
// Top of the cd_msf_position_unit testbench: clock, reset, command stimulus and result stalls.
// Depends on cdmsf_pkg, the block and cd_msf_position_unit_checker, which does the comparison.
module cd_msf_position_unit_tb;
    import cdmsf_pkg::*;

    localparam int unsigned ITEM_COUNT   = 1250;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 20;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    int                   fail_count;
    int                   outstanding;
    int unsigned          cycle_count = 0;
    int unsigned          sent_count  = 0;
    int unsigned          taken_count = 0;

    cd_msf_position_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    cd_msf_position_unit_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [7:0] to_bcd_byte(input int unsigned v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom());
    endfunction

    function automatic s_payload_t make_cmd(input logic [7:0] lm, input logic [7:0] ls,
                                            input logic [7:0] lf, input int unsigned addr,
                                            input logic [7:0] tm, input logic [7:0] ts,
                                            input logic [7:0] tf);
        s_payload_t c;
        c.load_minute  = lm;
        c.load_second  = ls;
        c.load_frame   = lf;
        c.seek_address = ADDR_W'(addr);
        c.track_minute = tm;
        c.track_second = ts;
        c.track_frame  = tf;
        return c;
    endfunction

    task automatic send_cmd(input logic [1:0] act, input s_payload_t cmd);
        int unsigned gap;
        gap = (sent_count % 200 >= 160) ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= S_TDATA_W'(cmd);
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        sent_count++;
    endtask

    task automatic send_load(input logic [7:0] lm, input logic [7:0] ls, input logic [7:0] lf);
        send_cmd(ACT_LOAD, make_cmd(lm, ls, lf, 0, any_byte(), any_byte(), any_byte()));
    endtask

    task automatic send_plain(input logic [1:0] act, input int unsigned addr);
        send_cmd(act, make_cmd(8'h00, 8'h00, 8'h00, addr, any_byte(), any_byte(), any_byte()));
    endtask

    // stall the result channel at random, with a stretch of free flow every 200 results
    initial begin
        int unsigned gap;
        m_tready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            @(negedge aclk);
            gap = (taken_count % 200 < 40) ? 0 : $urandom_range(0, 19);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            taken_count++;
        end
    end

    initial begin
        s_payload_t  cmd;
        logic [1:0]  act;
        int unsigned pick;
        int unsigned reps;
        int unsigned kind;
        int unsigned n;
        bit          paused;

        paused   = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ACT_QUERY;
        aresetn  = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_cmd(ACT_QUERY, make_cmd(8'h00, 8'h00, 8'h00, 0, 8'hFF, 8'hFF, 8'hFF));
        send_cmd(ACT_LOAD, make_cmd(8'h00, 8'h00, 8'h01, 0, 8'hFF, 8'hFF, 8'hFF));
        send_cmd(ACT_LOAD, make_cmd(8'hFF, 8'hFF, 8'hFF, 0, 8'h00, 8'h00, 8'h00));
        send_plain(ACT_STEP, 0);
        send_load(8'h00, 8'h59, 8'h74);
        send_plain(ACT_STEP, 0);
        send_load(8'h99, 8'h59, 8'h74);
        send_plain(ACT_STEP, 0);
        send_load(8'h09, 8'h59, 8'h74);
        send_plain(ACT_STEP, 0);
        send_load(8'h12, 8'h34, 8'h09);
        send_plain(ACT_STEP, 0);
        send_load(8'h12, 8'h34, 8'h76);
        send_plain(ACT_STEP, 0);
        send_load(8'h12, 8'h66, 8'h74);
        send_plain(ACT_STEP, 0);
        send_plain(ACT_SEEK, 0);
        send_plain(ACT_SEEK, SEEK_LIMIT);
        send_plain(ACT_SEEK, SEEK_LIMIT + 1);
        send_plain(ACT_SEEK, (1 << ADDR_W) - 1);
        send_plain(ACT_SEEK, FRAMES_PER_MIN - 1);
        send_plain(ACT_SEEK, FRAMES_PER_MIN);
        send_load(8'h45, 8'h30, 8'h20);
        send_load(8'h45, 8'h30, 8'h40);
        send_load(8'h45, 8'h30, 8'h60);

        n = 0;
        while (n < ITEM_COUNT) begin
            if (!paused && n >= ITEM_COUNT / 2) begin
                // hold off until every report is back
                s_tvalid <= 1'b0;
                wait (outstanding == 0);
                @(negedge aclk);
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                act = ACT_STEP;
            end else if (pick < 60) begin
                act = ACT_LOAD;
            end else if (pick < 80) begin
                act = ACT_SEEK;
            end else begin
                act = ACT_QUERY;
            end
            reps = (act == ACT_STEP) ? $urandom_range(1, 8) : 1;
            repeat (reps) begin
                cmd = s_payload_t'(S_PAYLOAD_W'({$urandom(), $urandom(), $urandom()}));
                if ($urandom_range(0, 3) != 0) begin
                    cmd.track_minute = to_bcd_byte($urandom_range(0, 99));
                    cmd.track_second = to_bcd_byte($urandom_range(0, 59));
                    cmd.track_frame  = to_bcd_byte($urandom_range(0, 74));
                end
                kind = $urandom_range(0, 3);
                if (act == ACT_LOAD && kind < 2) begin
                    cmd.load_minute = to_bcd_byte($urandom_range(0, 99));
                    cmd.load_second = to_bcd_byte($urandom_range(0, 59));
                    cmd.load_frame  = to_bcd_byte($urandom_range(0, 74));
                end else if (act == ACT_LOAD && kind == 2) begin
                    cmd.load_minute = $urandom_range(0, 1) ? to_bcd_byte($urandom_range(95, 99))
                                                           : to_bcd_byte($urandom_range(0, 99));
                    cmd.load_second = to_bcd_byte($urandom_range(57, 59));
                    cmd.load_frame  = to_bcd_byte($urandom_range(68, 74));
                end
                if (act == ACT_SEEK) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70) begin
                        cmd.seek_address = ADDR_W'($urandom_range(0, SEEK_LIMIT));
                    end else if (pick < 85) begin
                        cmd.seek_address = ADDR_W'($urandom_range(SEEK_LIMIT - 10,
                                                                  SEEK_LIMIT + 10));
                    end else begin
                        cmd.seek_address = ADDR_W'($urandom());
                    end
                end
                send_cmd(act, cmd);
                n++;
            end
        end

        s_tvalid <= 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
